// ===== sv/lts_pkg.sv =====
// Shared types and constants for the latency trace statistics block.
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

	localparam int TIME_BITS     = 48;
	localparam int KIND_BITS     = 3;
	localparam int NUM_KINDS     = 8;
	localparam int TRACE_DEPTH   = 1024;
	localparam int IDX_BITS      = 10;
	localparam int CNT_BITS      = 11;
	localparam int ADDR_BITS     = KIND_BITS + IDX_BITS;
	localparam int SUM_BITS      = 64;
	localparam int WIDE_BITS     = 128;
	localparam int OPB_BITS      = 64;
	localparam int DVS_BITS      = 32;
	localparam int ITER_BITS     = 8;
	localparam int MUL_ITERS     = 64;
	localparam int DIV_ITERS     = 128;
	localparam int SQRT_ITERS    = 64;
	localparam int IN_DATA_BITS  = 56;
	localparam int IN_USER_BITS  = 1;
	localparam int OUT_DATA_BITS = 256;
	localparam int STATUS_BITS   = 2;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_OK         = 2'd0,
		STAT_EMPTY      = 2'd1,
		STAT_INCOHERENT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ISSUE,
		ST_PIPE,
		ST_SQ,
		ST_SQ_WAIT,
		ST_JOB,
		ST_JOB_WAIT,
		ST_SEL_INIT,
		ST_SEL_RUN,
		ST_SEL_STEP,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		JOB_SQ,
		JOB_MEAN,
		JOB_NS2,
		JOB_SS,
		JOB_NN1,
		JOB_DIVV,
		JOB_SQRT
	} job_t;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic setup;
		logic issue;
		logic sel_mode;
		logic alu_start;
		job_t job;
		logic sel_init;
		logic sel_b;
		logic sel_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_report;
		logic incoherent;
		logic empty;
		logic idx_end;
		logic pipe_busy;
		logic alu_done;
		logic sel_last;
		logic n_even;
		logic n_multi;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== sv/latency_trace_statistics.sv =====
// Top level of the latency trace statistics block.
// Usage:
//   Input channel s_*: s_tuser[0] selects the item: 0 records a timestamp into
//   the trace of its kind, 1 requests statistics for a begin/end kind pair.
//   A record gives no result; records stream at one item
//   per cycle while the block is idle. A full trace drops the timestamp and
//   sets that kind's sticky overflow flag, reported as "biased".
//   Output channel m_*: one item per report, status in m_tuser.
//   Report computation: a delta scan over the pairs (one shared shift-add
//   multiplier squares each delta), then 48 radix passes for each median pick
//   (two picks for an even count), plus divide, multiply and square-root
//   iterations in the same shared unit. Empty or incoherent requests skip
//   the computation and go straight to the output state.
//   s_tready is low while a report is computed; the trace memory has one
//   write port and two read ports, so each radix pass reads one pair a cycle.
//   Reset clears the fill counts, overflow flags and the output valid; trace
//   contents are only read below the fill count and need no clearing.
//   A stalled receiver holds the result in the output register; records are
//   still taken, and a new report is computed but holds s_tready low in its
//   last state until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module latency_trace_statistics (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// kind [2:0], timestamp [50:3], end_kind [53:51], zero pad [55:54]
	input  wire logic [lts_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// operation [0]
	input  wire logic [lts_pkg::IN_USER_BITS-1:0]    s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// pair_count [10:0], minimum [58:11], maximum [106:59], average [154:107],
	// median [202:155], std_dev [250:203], biased [251], zero pad [255:252]
	output logic [lts_pkg::OUT_DATA_BITS-1:0]        m_tdata,
	// status [1:0]
	output logic [lts_pkg::STATUS_BITS-1:0]          m_tuser
);

	lts_pkg::cmd_t  cmd;
	lts_pkg::stat_t stat;
	logic           accept;

	// an item moves when both sides agree
	assign accept = s_tvalid & s_tready;

	lts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.stat     (stat),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	lts_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ===== sv/lts_alu.sv =====
// Shared multicycle unit: shift-add multiply, restoring divide, integer square root.
`timescale 1ns / 1ps
`default_nettype none

module lts_alu (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire lts_pkg::alu_op_t                   op,
	input  wire logic [lts_pkg::WIDE_BITS-1:0]      a,
	input  wire logic [lts_pkg::OPB_BITS-1:0]       b,
	output logic                                    done,
	output logic [lts_pkg::WIDE_BITS-1:0]           result
);

	logic                              busy_q;
	logic                              done_q;
	logic [lts_pkg::ITER_BITS-1:0]     cnt_q;
	lts_pkg::alu_op_t                  op_q;
	logic [lts_pkg::WIDE_BITS-1:0]     x_q, y_q, z_q;
	logic [lts_pkg::WIDE_BITS-1:0]     x_d, y_d, z_d;
	logic [lts_pkg::DVS_BITS-1:0]      dvs_q;
	logic [lts_pkg::DVS_BITS:0]        rem_sh;
	logic [lts_pkg::DVS_BITS:0]        rem_diff;
	logic [lts_pkg::WIDE_BITS-1:0]     sq_try;

	// one iteration of the selected operation
	always_comb begin
		x_d      = x_q;
		y_d      = y_q;
		z_d      = z_q;
		rem_sh   = {z_q[lts_pkg::DVS_BITS-1:0], x_q[lts_pkg::WIDE_BITS-1]};
		rem_diff = rem_sh - {1'b0, dvs_q};
		sq_try   = y_q + z_q;
		case (op_q)
			lts_pkg::ALU_MUL: begin
				if (z_q[0]) begin
					x_d = x_q + y_q;
				end
				y_d = y_q << 1;
				z_d = z_q >> 1;
			end
			lts_pkg::ALU_DIV: begin
				if (rem_sh >= {1'b0, dvs_q}) begin
					z_d = lts_pkg::WIDE_BITS'(rem_diff[lts_pkg::DVS_BITS-1:0]);
					x_d = {x_q[lts_pkg::WIDE_BITS-2:0], 1'b1};
				end else begin
					z_d = lts_pkg::WIDE_BITS'(rem_sh[lts_pkg::DVS_BITS-1:0]);
					x_d = {x_q[lts_pkg::WIDE_BITS-2:0], 1'b0};
				end
			end
			lts_pkg::ALU_SQRT: begin
				if (x_q >= sq_try) begin
					x_d = x_q - sq_try;
					y_d = (y_q >> 1) + z_q;
				end else begin
					y_d = y_q >> 1;
				end
				z_d = z_q >> 2;
			end
			default: begin
				z_d = z_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				case (op)
					lts_pkg::ALU_DIV: cnt_q <= lts_pkg::ITER_BITS'(lts_pkg::DIV_ITERS);
					lts_pkg::ALU_SQRT: cnt_q <= lts_pkg::ITER_BITS'(lts_pkg::SQRT_ITERS);
					default: cnt_q <= lts_pkg::ITER_BITS'(lts_pkg::MUL_ITERS);
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lts_pkg::ITER_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= op;
			case (op)
				lts_pkg::ALU_DIV: begin
					x_q   <= a;
					y_q   <= '0;
					z_q   <= '0;
					dvs_q <= b[lts_pkg::DVS_BITS-1:0];
				end
				lts_pkg::ALU_SQRT: begin
					x_q <= a;
					y_q <= '0;
					z_q <= lts_pkg::WIDE_BITS'(1) << (lts_pkg::WIDE_BITS - 2);
				end
				default: begin
					x_q <= '0;
					y_q <= a;
					z_q <= lts_pkg::WIDE_BITS'(b);
				end
			endcase
		end else if (busy_q) begin
			x_q <= x_d;
			y_q <= y_d;
			z_q <= z_d;
		end
	end

	assign done   = done_q;
	assign result = (op_q == lts_pkg::ALU_SQRT) ? y_q : x_q;

endmodule

`default_nettype wire

// ===== sv/lts_dpath.sv =====
// Datapath: trace memory, fill counts, delta pipeline, accumulators, selection and result register.
`timescale 1ns / 1ps
`default_nettype none

module lts_dpath (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   accept,
	input  wire logic [lts_pkg::IN_DATA_BITS-1:0]       s_tdata,
	input  wire logic [lts_pkg::IN_USER_BITS-1:0]       s_tuser,
	input  wire lts_pkg::cmd_t                          cmd,
	output lts_pkg::stat_t                              stat,
	input  wire logic                                   m_tready,
	output logic                                        m_tvalid,
	output logic [lts_pkg::OUT_DATA_BITS-1:0]           m_tdata,
	output logic [lts_pkg::STATUS_BITS-1:0]             m_tuser
);

	localparam int TB = lts_pkg::TIME_BITS;
	localparam int CB = lts_pkg::CNT_BITS;

	logic [TB-1:0] trace_mem [lts_pkg::NUM_KINDS*lts_pkg::TRACE_DEPTH];

	logic [CB-1:0]                 fill_q [lts_pkg::NUM_KINDS];
	logic [lts_pkg::NUM_KINDS-1:0] ovf_q;

	logic [lts_pkg::KIND_BITS-1:0] in_kind, in_end_kind;
	logic [TB-1:0]                 in_ts;
	logic                          rec_en;
	logic [CB-1:0]                 wr_fill;
	logic                          wr_room;

	logic [lts_pkg::KIND_BITS-1:0] bk_q, ek_q;
	logic [CB-1:0]                 n_q, idx_q, nb, ne;
	logic                          biased_q;
	lts_pkg::status_t              status_q;

	logic                          v_s1, v_s2;
	logic [TB-1:0]                 rd_b_s1, rd_e_s1, d_s2;

	logic [TB-1:0]                 min_q, max_q, avg_q, std_q;
	logic [lts_pkg::SUM_BITS-1:0]  sum_q;
	logic [lts_pkg::WIDE_BITS-1:0] sum2_q, var_q;
	logic [lts_pkg::DVS_BITS-1:0]  den_q;

	logic [TB-1:0]                 p_q, mask_q, bitsel_q, p_next, sel_a_q, sel_b_q;
	logic [CB-1:0]                 rank_q, cnt_q;
	logic                          sel_match;

	logic                          m_tvalid_q;
	logic [lts_pkg::OUT_DATA_BITS-1:0] m_tdata_q;
	logic [lts_pkg::STATUS_BITS-1:0]   m_tuser_q;
	logic [TB-1:0]                 med;

	lts_pkg::alu_op_t              alu_op;
	logic [lts_pkg::WIDE_BITS-1:0] alu_a, alu_res;
	logic [lts_pkg::OPB_BITS-1:0]  alu_b;
	logic                          alu_done;

	assign in_kind     = s_tdata[2:0];
	assign in_ts       = s_tdata[50:3];
	assign in_end_kind = s_tdata[53:51];
	assign rec_en      = accept && (s_tuser[0] == lts_pkg::OP_RECORD);
	assign wr_fill     = fill_q[in_kind];
	assign wr_room     = wr_fill < CB'(lts_pkg::TRACE_DEPTH);

	assign nb = fill_q[bk_q];
	assign ne = fill_q[ek_q];

	// trace memory: one write port for records, two read ports for the pair
	always_ff @(posedge clk) begin
		if (rec_en && wr_room) begin
			trace_mem[{in_kind, wr_fill[lts_pkg::IDX_BITS-1:0]}] <= in_ts;
		end
		rd_b_s1 <= trace_mem[{bk_q, idx_q[lts_pkg::IDX_BITS-1:0]}];
		rd_e_s1 <= trace_mem[{ek_q, idx_q[lts_pkg::IDX_BITS-1:0]}];
	end

	// ALU operand routing
	always_comb begin
		alu_op = lts_pkg::ALU_MUL;
		alu_a  = lts_pkg::WIDE_BITS'(d_s2);
		alu_b  = lts_pkg::OPB_BITS'(d_s2);
		case (cmd.job)
			lts_pkg::JOB_MEAN: begin
				alu_op = lts_pkg::ALU_DIV;
				alu_a  = lts_pkg::WIDE_BITS'(sum_q);
				alu_b  = lts_pkg::OPB_BITS'(n_q);
			end
			lts_pkg::JOB_NS2: begin
				alu_a = sum2_q;
				alu_b = lts_pkg::OPB_BITS'(n_q);
			end
			lts_pkg::JOB_SS: begin
				alu_a = lts_pkg::WIDE_BITS'(sum_q);
				alu_b = sum_q;
			end
			lts_pkg::JOB_NN1: begin
				alu_a = lts_pkg::WIDE_BITS'(n_q);
				alu_b = lts_pkg::OPB_BITS'(n_q - 1'b1);
			end
			lts_pkg::JOB_DIVV: begin
				alu_op = lts_pkg::ALU_DIV;
				alu_a  = var_q;
				alu_b  = lts_pkg::OPB_BITS'(den_q);
			end
			lts_pkg::JOB_SQRT: begin
				alu_op = lts_pkg::ALU_SQRT;
				alu_a  = var_q;
				alu_b  = '0;
			end
			default: begin
				alu_op = lts_pkg::ALU_MUL;
			end
		endcase
	end

	lts_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.alu_start),
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.done   (alu_done),
		.result (alu_res)
	);

	// radix selection: count deltas under the current prefix with a zero at the current bit
	assign sel_match = (((d_s2 ^ p_q) & mask_q) == '0) && ((d_s2 & bitsel_q) == '0);

	always_comb begin
		if (rank_q < cnt_q) begin
			p_next = p_q;
		end else begin
			p_next = p_q | bitsel_q;
		end
	end

	assign med = n_q[0] ? sel_a_q :
		(sel_a_q >> 1) + (sel_b_q >> 1) + TB'(sel_a_q[0] & sel_b_q[0]);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < lts_pkg::NUM_KINDS; k++) begin
				fill_q[k] <= '0;
			end
			ovf_q      <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (rec_en) begin
				if (wr_room) begin
					fill_q[in_kind] <= wr_fill + 1'b1;
				end else begin
					ovf_q[in_kind] <= 1'b1;
				end
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.setup || cmd.sel_init || cmd.sel_step) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && (s_tuser[0] == lts_pkg::OP_REPORT)) begin
			bk_q <= in_kind;
			ek_q <= in_end_kind;
		end
		if (v_s1) begin
			d_s2 <= rd_e_s1 - rd_b_s1;
		end
		if (cmd.setup) begin
			n_q      <= ne;
			biased_q <= ovf_q[bk_q] | ovf_q[ek_q];
			if (nb < ne) begin
				status_q <= lts_pkg::STAT_INCOHERENT;
			end else if (ne == '0) begin
				status_q <= lts_pkg::STAT_EMPTY;
			end else begin
				status_q <= lts_pkg::STAT_OK;
			end
			min_q  <= '1;
			max_q  <= '0;
			sum_q  <= '0;
			sum2_q <= '0;
			std_q  <= '0;
		end
		if (v_s2) begin
			if (cmd.sel_mode) begin
				if (sel_match) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else begin
				if (d_s2 < min_q) begin
					min_q <= d_s2;
				end
				if (d_s2 > max_q) begin
					max_q <= d_s2;
				end
				sum_q <= sum_q + lts_pkg::SUM_BITS'(d_s2);
			end
		end
		if (alu_done) begin
			case (cmd.job)
				lts_pkg::JOB_SQ:   sum2_q <= sum2_q + alu_res;
				lts_pkg::JOB_MEAN: avg_q  <= alu_res[TB-1:0];
				lts_pkg::JOB_NS2:  var_q  <= alu_res;
				lts_pkg::JOB_SS:   var_q  <= var_q - alu_res;
				lts_pkg::JOB_NN1:  den_q  <= alu_res[lts_pkg::DVS_BITS-1:0];
				lts_pkg::JOB_DIVV: var_q  <= alu_res;
				lts_pkg::JOB_SQRT: std_q  <= alu_res[TB-1:0];
				default:           var_q  <= var_q;
			endcase
		end
		if (cmd.sel_init) begin
			rank_q   <= cmd.sel_b ? (n_q >> 1) - 1'b1 : (n_q >> 1);
			p_q      <= '0;
			mask_q   <= '0;
			bitsel_q <= TB'(1) << (TB - 1);
			cnt_q    <= '0;
		end
		if (cmd.sel_step) begin
			if (!(rank_q < cnt_q)) begin
				rank_q <= rank_q - cnt_q;
			end
			p_q      <= p_next;
			mask_q   <= mask_q | bitsel_q;
			bitsel_q <= bitsel_q >> 1;
			cnt_q    <= '0;
			if (bitsel_q[0]) begin
				if (cmd.sel_b) begin
					sel_b_q <= p_next;
				end else begin
					sel_a_q <= p_next;
				end
			end
		end
		if (cmd.load_out) begin
			m_tuser_q <= status_q;
			if (status_q == lts_pkg::STAT_OK) begin
				m_tdata_q <= {4'b0, biased_q, std_q, med, avg_q, max_q, min_q, n_q};
			end else begin
				m_tdata_q <= {4'b0, biased_q, 251'b0};
			end
		end
	end

	assign stat.is_report  = (s_tuser[0] == lts_pkg::OP_REPORT);
	assign stat.incoherent = nb < ne;
	assign stat.empty      = ne == '0;
	assign stat.idx_end    = idx_q == n_q;
	assign stat.pipe_busy  = v_s1 | v_s2;
	assign stat.alu_done   = alu_done;
	assign stat.sel_last   = bitsel_q[0];
	assign stat.n_even     = ~n_q[0];
	assign stat.n_multi    = n_q > CB'(1);
	assign stat.out_free   = ~m_tvalid_q | m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ===== sv/lts_ctrl.sv =====
// Controller state machine sequencing the report computation.
`timescale 1ns / 1ps
`default_nettype none

module lts_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire lts_pkg::stat_t   stat,
	output lts_pkg::cmd_t         cmd,
	output logic                  s_tready
);

	lts_pkg::state_t state_q, state_d;
	lts_pkg::job_t   job_q, job_d;
	logic            which_q, which_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lts_pkg::ST_IDLE;
			job_q   <= lts_pkg::JOB_SQ;
			which_q <= 1'b0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			which_q <= which_d;
		end
	end

	always_comb begin
		state_d = state_q;
		job_d   = job_q;
		which_d = which_q;
		case (state_q)
			lts_pkg::ST_IDLE: begin
				if (accept && stat.is_report) begin
					state_d = lts_pkg::ST_CHECK;
				end
			end
			lts_pkg::ST_CHECK: begin
				if (stat.incoherent || stat.empty) begin
					state_d = lts_pkg::ST_OUT;
				end else begin
					state_d = lts_pkg::ST_ISSUE;
				end
			end
			lts_pkg::ST_ISSUE: state_d = lts_pkg::ST_PIPE;
			lts_pkg::ST_PIPE: begin
				state_d = lts_pkg::ST_SQ;
				job_d   = lts_pkg::JOB_SQ;
			end
			lts_pkg::ST_SQ: state_d = lts_pkg::ST_SQ_WAIT;
			lts_pkg::ST_SQ_WAIT: begin
				if (stat.alu_done) begin
					if (stat.idx_end) begin
						state_d = lts_pkg::ST_JOB;
						job_d   = lts_pkg::JOB_MEAN;
					end else begin
						state_d = lts_pkg::ST_ISSUE;
					end
				end
			end
			lts_pkg::ST_JOB: state_d = lts_pkg::ST_JOB_WAIT;
			lts_pkg::ST_JOB_WAIT: begin
				if (stat.alu_done) begin
					state_d = lts_pkg::ST_JOB;
					case (job_q)
						lts_pkg::JOB_MEAN: begin
							state_d = lts_pkg::ST_SEL_INIT;
							which_d = 1'b0;
						end
						lts_pkg::JOB_NS2:  job_d = lts_pkg::JOB_SS;
						lts_pkg::JOB_SS:   job_d = lts_pkg::JOB_NN1;
						lts_pkg::JOB_NN1:  job_d = lts_pkg::JOB_DIVV;
						lts_pkg::JOB_DIVV: job_d = lts_pkg::JOB_SQRT;
						default:           state_d = lts_pkg::ST_OUT;
					endcase
				end
			end
			lts_pkg::ST_SEL_INIT: state_d = lts_pkg::ST_SEL_RUN;
			lts_pkg::ST_SEL_RUN: begin
				if (stat.idx_end && !stat.pipe_busy) begin
					state_d = lts_pkg::ST_SEL_STEP;
				end
			end
			lts_pkg::ST_SEL_STEP: begin
				if (!stat.sel_last) begin
					state_d = lts_pkg::ST_SEL_RUN;
				end else if (!which_q && stat.n_even) begin
					state_d = lts_pkg::ST_SEL_INIT;
					which_d = 1'b1;
				end else if (stat.n_multi) begin
					state_d = lts_pkg::ST_JOB;
					job_d   = lts_pkg::JOB_NS2;
				end else begin
					state_d = lts_pkg::ST_OUT;
				end
			end
			lts_pkg::ST_OUT: begin
				if (stat.out_free) begin
					state_d = lts_pkg::ST_IDLE;
				end
			end
			default: state_d = lts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.job       = job_q;
		cmd.sel_b     = which_q;
		s_tready      = 1'b0;
		case (state_q)
			lts_pkg::ST_IDLE:     s_tready = 1'b1;
			lts_pkg::ST_CHECK:    cmd.setup = 1'b1;
			lts_pkg::ST_ISSUE:    cmd.issue = 1'b1;
			lts_pkg::ST_SQ:       cmd.alu_start = 1'b1;
			lts_pkg::ST_JOB:      cmd.alu_start = 1'b1;
			lts_pkg::ST_SEL_INIT: cmd.sel_init = 1'b1;
			lts_pkg::ST_SEL_RUN: begin
				cmd.sel_mode = 1'b1;
				cmd.issue    = ~stat.idx_end;
			end
			lts_pkg::ST_SEL_STEP: cmd.sel_step = 1'b1;
			lts_pkg::ST_OUT:      cmd.load_out = stat.out_free;
			default:              s_tready = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/lts_checker.sv =====
// Port-level checker for the latency trace statistics block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module lts_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [lts_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	input wire logic [lts_pkg::STATUS_BITS-1:0]     m_tuser
);

	logic ok;
	assign ok = m_tvalid && (m_tuser == lts_pkg::STAT_OK);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != lts_pkg::STAT_OK) |-> m_tdata[250:0] == '0)
		else $error("failed report carries statistics");

	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		ok |-> (m_tdata[10:0] != '0) && (m_tdata[58:11] <= m_tdata[106:59]))
		else $error("ok report with no pairs or min above max");

	a_ok_order: assert property (@(posedge clk) disable iff (!arst_n)
		ok |-> (m_tdata[58:11] <= m_tdata[202:155]) && (m_tdata[202:155] <= m_tdata[106:59])
			&& (m_tdata[58:11] <= m_tdata[154:107]) && (m_tdata[154:107] <= m_tdata[106:59]))
		else $error("median or average outside min/max");

endmodule

bind latency_trace_statistics lts_checker u_lts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the latency trace statistics block.
`timescale 1ns / 1ps
`default_nettype none

class stats_scoreboard;
	typedef struct {
		lts_pkg::status_t status;
		logic [10:0] pair_count;
		logic [47:0] minimum;
		logic [47:0] maximum;
		logic [47:0] average;
		logic [47:0] median;
		logic [47:0] std_dev;
		logic        biased;
	} report_t;

	logic [47:0] trace [lts_pkg::NUM_KINDS][lts_pkg::TRACE_DEPTH];
	int          fill [lts_pkg::NUM_KINDS];
	bit          overflow [lts_pkg::NUM_KINDS];
	report_t     pending_reports [$];
	int          errors;

	function new();
		errors = 0;
		foreach (fill[k]) begin
			fill[k] = 0;
			overflow[k] = 0;
		end
	endfunction

	// Exact statistics for one begin/end kind pair.
	function report_t compute_report(int bk, int ek);
		report_t r;
		logic [47:0] deltas [$];
		logic [47:0] d, a, b, tmp;
		logic [63:0] sum;
		logic [127:0] sum_sq, num, c;
		int n, j;
		r.status = lts_pkg::STAT_OK;
		r.pair_count = '0;
		r.minimum = '0;
		r.maximum = '0;
		r.average = '0;
		r.median = '0;
		r.std_dev = '0;
		r.biased = overflow[bk] | overflow[ek];
		if (fill[bk] < fill[ek]) begin
			r.status = lts_pkg::STAT_INCOHERENT;
			return r;
		end
		if (fill[ek] == 0) begin
			r.status = lts_pkg::STAT_EMPTY;
			return r;
		end
		n = fill[ek];
		sum = '0;
		sum_sq = '0;
		r.minimum = '1;
		for (int i = 0; i < n; i++) begin
			d = trace[ek][i] - trace[bk][i];
			deltas = {deltas, d};
			if (d < r.minimum) r.minimum = d;
			if (d > r.maximum) r.maximum = d;
			sum += 64'(d);
			sum_sq += 128'(d) * 128'(d);
		end
		// insertion sort, ascending
		for (int i = 1; i < n; i++) begin
			tmp = deltas[i];
			j = i - 1;
			while (j >= 0 && deltas[j] > tmp) begin
				deltas[j + 1] = deltas[j];
				j--;
			end
			deltas[j + 1] = tmp;
		end
		if (n % 2 == 1) begin
			r.median = deltas[n / 2];
		end else begin
			a = deltas[n / 2];
			b = deltas[n / 2 - 1];
			r.median = (a >> 1) + (b >> 1) + (a & b & 48'd1);
		end
		r.pair_count = 11'(n);
		r.average = 48'(sum / 64'(n));
		if (n > 1) begin
			num = 128'(n) * sum_sq - 128'(sum) * 128'(sum);
			num = num / (128'(n) * 128'(n - 1));
			c = '0;
			for (int bit_idx = 63; bit_idx >= 0; bit_idx--) begin
				if ((c | (128'd1 << bit_idx)) * (c | (128'd1 << bit_idx)) <= num)
					c = c | (128'd1 << bit_idx);
			end
			r.std_dev = 48'(c);
		end
		return r;
	endfunction

	function void note_item(logic op, logic [lts_pkg::IN_DATA_BITS-1:0] data);
		int bk, ek;
		bk = int'(data[2:0]);
		ek = int'(data[53:51]);
		if (op == lts_pkg::OP_RECORD) begin
			if (fill[bk] < lts_pkg::TRACE_DEPTH) begin
				trace[bk][fill[bk]] = data[50:3];
				fill[bk]++;
			end else begin
				overflow[bk] = 1;
			end
		end else begin
			pending_reports = {pending_reports, compute_report(bk, ek)};
		end
	endfunction

	function void check_report(logic [1:0] status, logic [255:0] data);
		report_t e;
		if (pending_reports.size() == 0) begin
			$error("unexpected report item, status %0d", status);
			errors++;
			return;
		end
		e = pending_reports.pop_front();
		if (status !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, status);
			errors++;
		end
		if (data[10:0] !== e.pair_count) begin
			$error("pair_count: expected %0d, got %0d", e.pair_count, data[10:0]);
			errors++;
		end
		if (data[58:11] !== e.minimum) begin
			$error("minimum: expected %0h, got %0h", e.minimum, data[58:11]);
			errors++;
		end
		if (data[106:59] !== e.maximum) begin
			$error("maximum: expected %0h, got %0h", e.maximum, data[106:59]);
			errors++;
		end
		if (data[154:107] !== e.average) begin
			$error("average: expected %0h, got %0h", e.average, data[154:107]);
			errors++;
		end
		if (data[202:155] !== e.median) begin
			$error("median: expected %0h, got %0h", e.median, data[202:155]);
			errors++;
		end
		if (data[250:203] !== e.std_dev) begin
			$error("std_dev: expected %0h, got %0h", e.std_dev,
				data[250:203]);
			errors++;
		end
		if (data[251] !== e.biased) begin
			$error("biased: expected %0b, got %0b", e.biased, data[251]);
			errors++;
		end
	endfunction
endclass

module testbench;

	localparam int WATCHDOG_LIMIT = 800000;
	localparam int RANDOM_ITEMS   = 500;
	localparam int SMALL_TRACE    = 24;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [lts_pkg::IN_DATA_BITS-1:0]  s_tdata;
	logic [lts_pkg::IN_USER_BITS-1:0]  s_tuser;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [lts_pkg::OUT_DATA_BITS-1:0] m_tdata;
	logic [lts_pkg::STATUS_BITS-1:0]   m_tuser;

	stats_scoreboard sb;
	int sender_idle_pct;
	int receiver_stall_pct;
	int quiet_cycles;

	latency_trace_statistics DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	// Note accepted items and check results at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_item(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready) sb.check_report(m_tuser, m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	// Receiver backpressure.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Entered and left at a falling edge.
	task automatic send_item(logic op, logic [2:0] kind, logic [47:0] stamp,
		logic [2:0] end_kind);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, end_kind, stamp, kind};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic record(logic [2:0] kind, logic [47:0] stamp);
		send_item(lts_pkg::OP_RECORD, kind, stamp, 3'($urandom));
	endtask

	task automatic report(logic [2:0] bk, logic [2:0] ek);
		send_item(lts_pkg::OP_REPORT, bk, 48'({$urandom, $urandom}), ek);
	endtask

	function automatic logic [47:0] rand_stamp();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 48'($urandom_range(0, 1000));
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	initial begin
		int k, bk, ek;
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 0;
		quiet_cycles = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty, incoherent, single pair, extremes, wrap, zero delta
		report(3, 5);
		record(1, 48'd0);
		report(1, 2);
		report(2, 1);
		record(2, '1);
		report(1, 2);
		record(1, '1);
		record(2, 48'd0);
		report(1, 2);
		record(3, 48'd5);
		record(4, 48'd5);
		report(3, 4);
		report(6, 6);
		record(5, 48'h800000000000);
		record(6, 48'h7fffffffffff);
		report(5, 6);
		report(6, 5);
		record(7, 48'h123456789abc);
		report(7, 7);

		// fill kind 0 past its depth so it overflows
		for (int i = 0; i < lts_pkg::TRACE_DEPTH + 6; i++)
			record(0, 48'({$urandom, $urandom}));
		report(0, 2);
		report(2, 0);

		// random part in four backpressure phases
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case (i / (RANDOM_ITEMS / 4))
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
				default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
			endcase
			if ($urandom_range(0, 99) < 25) begin
				bk = $urandom_range(0, 7);
				ek = $urandom_range(0, 7);
				// keep the full trace off the end side unless it is incoherent
				if (bk == 0 && ek == 0) ek = $urandom_range(1, 7);
				report(3'(bk), 3'(ek));
			end else begin
				k = $urandom_range(0, 7);
				if (sb.fill[k] >= SMALL_TRACE) k = 0;
				record(3'(k), rand_stamp());
			end
		end

		// full-depth pair count
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		report(0, 0);
		s_tvalid <= 1'b0;

		while (sb.pending_reports.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule

`default_nettype wire
